FILE: rtl/raster_line_interrupt_timer_unit_macros.svh
// Assertion macros used by the checker
`ifndef RASTER_LINE_INTERRUPT_TIMER_UNIT_MACROS_SVH
`define RASTER_LINE_INTERRUPT_TIMER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RLIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlit: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RLIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlit: next-cycle check failed");

`endif

FILE: rtl/rlit_pkg.sv
package rlit_pkg;

    localparam int LINES_PER_FRAME   = 264;
    localparam int FRAME_COUNT_WIDTH = 16;
    localparam int LINE_W            = $clog2(LINES_PER_FRAME + 1);
    localparam int POS_W             = 32;
    localparam int OUT_COUNT_W       = 16;
    localparam int DIV_W             = 8;
    localparam int AGE_W             = 4;
    localparam int CFG_DATA_W        = 8;

    // (pos + 3) / 384 = ((pos + 3) >> 7) / 3, the /3 by reciprocal
    localparam logic [POS_W-1:0] POS_ROUND = 32'd3;
    localparam int DIV_SHIFT   = 7;
    localparam int QIN_W       = POS_W - DIV_SHIFT;
    localparam int STEP_W      = 24;
    localparam logic [STEP_W-1:0] RECIP3 = 24'hAAAAAB;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W      = QIN_W + STEP_W;

    localparam logic [POS_W-1:0] NO_TARGET   = 32'd1000;
    localparam logic [AGE_W-1:0] AGE_LIMIT   = 4'd7;
    localparam logic [AGE_W-1:0] AGE_MAX     = 4'd15;
    localparam logic [DIV_W-1:0] DIV_RESET   = 8'd8;

    typedef enum logic {
        CFG_RASTER_MODE   = 1'b0,
        CFG_FRAME_DIVIDER = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_KICK  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]       command;
        logic             line_irq_enable;
        logic             reload_at_frame;
        logic             auto_repeat;
        logic             counter_stop;
        logic [POS_W-1:0] timer_position;
    } t_in_item;

    typedef struct packed {
        logic                   line_irq;
        logic                   frame_irq;
        logic                   cpu_reset;
        logic [OUT_COUNT_W-1:0] frame_count;
    } t_out_item;

    typedef struct packed {
        t_cmd              cmd;
        logic              en;
        logic              reload;
        logic              repeat_en;
        logic              stop;
        logic [STEP_W-1:0] step;
    } t_stage;

endpackage

FILE: rtl/raster_line_interrupt_timer_unit.sv
// Raster line interrupt timer.
// Input channel: i_in_valid / o_in_stall with i_in_data, one command per item
// (scanline tick, end of frame, watchdog kick) plus control bits and position.
// Output channel: o_out_valid / i_out_stall with o_out_data, exactly one result
// item per input item, in order.
// Configuration: i_cfg_we writes i_cfg_data to the register chosen by
// i_cfg_idx (raster mode, frame divider); write only while no item is in flight.
// An accepted item is held in the input register, then moves to the result
// register once that is free. Throughput: one item per cycle unless the
// receiver stalls; the position divide is done while the item is captured,
// the state update between the input and result registers.
// A stalled result stays in the result register; the input register can still
// hand over its item in the cycle the result is taken, so o_in_stall rises
// only when both registers are full and the receiver stalls.
// Reset clears the pipeline, the state (target line 1000, counters zero) and
// the configuration (raster mode off, frame divider 8).
module raster_line_interrupt_timer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rlit_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rlit_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  rlit_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [rlit_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                         r_s1_vld;
    rlit_pkg::t_stage             r_s1;
    logic                         r_out_vld;
    rlit_pkg::t_out_item          r_out;
    logic [rlit_pkg::STEP_W-1:0]  step;
    rlit_pkg::t_out_item          result;
    logic                         out_ready, s1_move, in_take;

    assign out_ready   = !r_out_vld || !i_out_stall;
    assign s1_move     = r_s1_vld && out_ready;
    assign o_in_stall  = r_s1_vld && !out_ready;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    rlit_step u_step (
        .i_pos  (i_in_data.timer_position),
        .o_step (step)
    );

    rlit_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (s1_move),
        .i_stage    (r_s1),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!r_s1_vld || s1_move) begin
                r_s1_vld <= i_in_valid;
            end
            if (out_ready) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.cmd       <= rlit_pkg::t_cmd'(i_in_data.command);
            r_s1.en        <= i_in_data.line_irq_enable;
            r_s1.reload    <= i_in_data.reload_at_frame;
            r_s1.repeat_en <= i_in_data.auto_repeat;
            r_s1.stop      <= i_in_data.counter_stop;
            r_s1.step      <= step;
        end
        if (s1_move) begin
            r_out <= result;
        end
    end

endmodule

FILE: rtl/rlit_step.sv
module rlit_step (
    input  logic [rlit_pkg::POS_W-1:0]  i_pos,
    output logic [rlit_pkg::STEP_W-1:0] o_step
);

    logic [rlit_pkg::POS_W-1:0]  sum;
    logic [rlit_pkg::QIN_W-1:0]  qin;
    logic [rlit_pkg::PROD_W-1:0] prod;

    assign sum    = i_pos + rlit_pkg::POS_ROUND;
    assign qin    = sum[rlit_pkg::POS_W-1:rlit_pkg::DIV_SHIFT];
    assign prod   = rlit_pkg::PROD_W'(qin) * rlit_pkg::PROD_W'(rlit_pkg::RECIP3);
    assign o_step = prod[rlit_pkg::PROD_W-1:rlit_pkg::RECIP_SHIFT];

endmodule

FILE: rtl/rlit_core.sv
module rlit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  rlit_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [rlit_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_adv,
    input  rlit_pkg::t_stage                  i_stage,
    output rlit_pkg::t_out_item               o_result
);

    logic                                   r_raster;
    logic [rlit_pkg::DIV_W-1:0]             r_fdiv;
    logic [rlit_pkg::LINE_W-1:0]            r_line, n_line;
    logic [rlit_pkg::POS_W-1:0]             r_target, n_target;
    logic [rlit_pkg::DIV_W-1:0]             r_div, n_div;
    logic [rlit_pkg::FRAME_COUNT_WIDTH-1:0] r_fc, n_fc;
    logic [rlit_pkg::AGE_W-1:0]             r_age, n_age;
    logic hit, advance, line_irq, frame_irq, cpu_rst;

    assign hit = i_stage.en && (rlit_pkg::POS_W'(r_line) == r_target);

    always_comb begin
        n_line    = r_line;
        n_target  = r_target;
        n_div     = r_div;
        n_fc      = r_fc;
        n_age     = r_age;
        advance   = 1'b0;
        line_irq  = 1'b0;
        frame_irq = 1'b0;
        cpu_rst   = 1'b0;
        unique case (i_stage.cmd)
            rlit_pkg::CMD_TICK: begin
                if (r_raster && (r_line < rlit_pkg::LINE_W'(rlit_pkg::LINES_PER_FRAME))) begin
                    if (hit && i_stage.repeat_en) begin
                        n_target = r_target + rlit_pkg::POS_W'(i_stage.step);
                    end
                    line_irq = hit;
                    n_line   = r_line + rlit_pkg::LINE_W'(1);
                end
            end
            rlit_pkg::CMD_FRAME: begin
                n_line = '0;
                if (r_raster) begin
                    n_target = i_stage.reload ? rlit_pkg::POS_W'(i_stage.step)
                                              : rlit_pkg::NO_TARGET;
                end
                advance = r_raster || !i_stage.stop;
                if (r_age != rlit_pkg::AGE_MAX) begin
                    n_age = r_age + rlit_pkg::AGE_W'(1);
                end
                cpu_rst   = n_age > rlit_pkg::AGE_LIMIT;
                frame_irq = 1'b1;
            end
            rlit_pkg::CMD_KICK: begin
                n_age = '0;
            end
            default: begin
            end
        endcase
        if (advance) begin
            if (r_div >= r_fdiv) begin
                n_div = rlit_pkg::DIV_W'(1);
                n_fc  = r_fc + rlit_pkg::FRAME_COUNT_WIDTH'(1);
            end else begin
                n_div = r_div + rlit_pkg::DIV_W'(1);
            end
        end
    end

    always_comb begin
        o_result.line_irq    = line_irq;
        o_result.frame_irq   = frame_irq;
        o_result.cpu_reset   = cpu_rst;
        o_result.frame_count = rlit_pkg::OUT_COUNT_W'(n_fc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raster <= 1'b0;
            r_fdiv   <= rlit_pkg::DIV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rlit_pkg::CFG_RASTER_MODE:   r_raster <= i_cfg_data[0];
                rlit_pkg::CFG_FRAME_DIVIDER: r_fdiv   <= i_cfg_data[rlit_pkg::DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= '0;
            r_target <= rlit_pkg::NO_TARGET;
            r_div    <= '0;
            r_fc     <= '0;
            r_age    <= '0;
        end else if (i_adv) begin
            r_line   <= n_line;
            r_target <= n_target;
            r_div    <= n_div;
            r_fc     <= n_fc;
            r_age    <= n_age;
        end
    end

endmodule

FILE: rtl/rlit_checker.sv
`include "raster_line_interrupt_timer_unit_macros.svh"

module rlit_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rlit_pkg::t_out_item o_out_data
);

    `RLIT_ASSERT_NOW(a_irq_exclusive, o_out_valid && o_out_data.line_irq, !o_out_data.frame_irq)
    `RLIT_ASSERT_NOW(a_reset_at_frame, o_out_valid && o_out_data.cpu_reset, o_out_data.frame_irq)
    `RLIT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind raster_line_interrupt_timer_unit rlit_checker u_rlit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
